[rtl/zsn_pkg.sv]
// types and constants shared by the window z-score normalizer
`default_nettype none
package zsn_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 16;
    localparam int SCORE_BITS  = 32;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_zsn_in;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic                         dropped;
        logic                         final_res;
    } t_zsn_out;
endpackage
`default_nettype wire

[rtl/zsn_ram.sv]
// generic single-write, registered-read ram
`default_nettype none
module zsn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/zsn_sqrt.sv]
// bit-serial integer square root, one root bit per cycle
`default_nettype none
module zsn_sqrt #(
    parameter int VW = 62
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [VW-1:0]     i_value,
    output logic                   o_done,
    output logic [VW/2-1:0]        o_root
);
    localparam int RW = VW / 2;
    localparam int CNW = $clog2(RW + 1);

    logic [VW-1:0]  r_v;
    logic [RW:0]    r_rem;
    logic [RW-1:0]  r_root;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [RW+2:0]  w_rem2;
    logic [RW+2:0]  w_trial;
    logic           w_ge;

    assign w_rem2  = {r_rem, r_v[VW-1:VW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= i_value;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_v <= {r_v[VW-3:0], 2'b00};
                if (w_ge) begin
                    r_rem  <= (RW+1)'(w_rem2 - w_trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2[RW:0];
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

[rtl/zsn_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module zsn_div #(
    parameter int DW = 56,
    parameter int RW = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [RW-1:0] i_den,
    output logic               o_done,
    output logic [DW-1:0]      o_quot
);
    localparam int CNW = $clog2(DW + 1);

    logic [DW-1:0]  r_q;
    logic [RW-1:0]  r_rem;
    logic [RW-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [RW:0]    w_rem2;
    logic           w_ge;

    assign w_rem2 = {r_rem, r_q[DW-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[DW-2:0], w_ge};
                r_rem <= w_ge ? RW'(w_rem2 - {1'b0, r_den}) : w_rem2[RW-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

[rtl/window_zscore_normalizer.sv]
// top level of the window z-score normalizer
//
//  channel | direction | handshake         | payload
//  input   | in        | i_valid / o_stall | i_data  (sample, last)
//  output  | out       | o_valid / i_stall | o_data  (score, dropped, final_res)
//  config  | in        | i_cfg_we          | i_cfg_wdata (gain)
//
// a sample that is stored passes through the load and acc states, a dropped one only through load
// closing a window: a shift-add of n*Q over the bits of n, a state to start the root,
// and then the bit-serial square root
// each result beat: read, numerator and product states, the bit-serial divider
// and an output state; the divider is skipped when D is 0
// synchronous active-low reset empties the window and sets gain to 1.0
// o_stall is high in every state but load; an output beat holds on i_stall
`default_nettype none
module window_zscore_normalizer #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire zsn_pkg::t_zsn_in  i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output zsn_pkg::t_zsn_out      o_data,
    input  wire logic              i_cfg_we,
    input  wire logic [zsn_pkg::GAIN_BITS-1:0] i_cfg_wdata
);
    import zsn_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);   // count width
    localparam int AW   = $clog2(MAX_SAMPLES);       // store address
    localparam int SUMW = SB + CW;                   // running sum
    localparam int SQW  = 2 * SB + CW;               // sum of squares
    localparam int VW   = 2 * SUMW;                  // n*Q - S*S
    localparam int RW   = VW / 2;                    // root
    localparam int NW   = SUMW + 1;                  // n*x - S
    localparam int DW   = NW + GAIN_BITS + 8;        // dividend

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_ACC  = 4'd1;
    localparam logic [3:0] ST_NQ   = 4'd2;
    localparam logic [3:0] ST_SS   = 4'd3;
    localparam logic [3:0] ST_ROOT = 4'd4;
    localparam logic [3:0] ST_RD   = 4'd5;
    localparam logic [3:0] ST_NUM  = 4'd6;
    localparam logic [3:0] ST_PROD = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    localparam logic [DW-1:0] POS_LIM = DW'(64'h7FFF_FFFF);
    localparam logic [DW-1:0] NEG_LIM = DW'(64'h8000_0000);

    logic [3:0]             r_state;
    logic [GAIN_BITS-1:0]   r_gain;
    logic [CW-1:0]          r_count;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sq;
    logic                   r_ovf;
    logic signed [SB-1:0]   r_x;
    logic                   r_last;
    logic [CW-1:0]          r_nsh;       // n, shifted right a bit a cycle
    logic [VW-1:0]          r_qsh;       // Q, shifted left a bit a cycle
    logic [VW-1:0]          r_nq;
    logic [RW-1:0]          r_d;
    logic [CW-1:0]          r_k;
    logic signed [NW-1:0]   r_num;
    logic [SCORE_BITS-1:0]  r_score;

    logic                   w_acc;
    logic                   w_full;
    logic [SB-1:0]          w_rd;
    logic [SUMW-1:0]        w_smag;
    logic [VW-1:0]          w_ss;
    logic                   w_sq_start;
    logic                   w_sq_done;
    logic [RW-1:0]          w_root;
    logic signed [NW-1:0]   w_nx;
    logic [NW-1:0]          w_nmag;
    logic [DW-1:0]          w_dvd;
    logic                   w_dv_start;
    logic                   w_dv_done;
    logic [DW-1:0]          w_quot;
    logic [SCORE_BITS-1:0]  w_sat;
    logic                   w_fin;
    logic [2*SB-1:0]        w_x2;
    logic [VW-1:0]          r_ss;

    assign w_acc  = i_valid && !o_stall;
    assign w_full = (r_count == CW'(MAX_SAMPLES));
    assign o_stall = (r_state != ST_LOAD);

    // sample store, written in arrival order, read back one entry per beat
    zsn_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && !w_full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_data.sample),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_rd)
    );

    // closing arithmetic
    assign w_x2   = (2*SB)'(r_x * r_x);
    assign w_smag = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign w_ss   = VW'(w_smag * w_smag);

    assign w_sq_start = (r_state == ST_SS);
    zsn_sqrt #(.VW(VW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (r_nq - r_ss),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // per-sample numerator n*x - S and scaled dividend |num|*gain*256
    assign w_nx   = NW'($signed({1'b0, r_count})) * NW'($signed(w_rd));
    assign w_nmag = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign w_dvd  = {(DW-8)'(w_nmag * r_gain), 8'h00};

    assign w_dv_start = (r_state == ST_PROD) && (r_d != '0);
    zsn_div #(.DW(DW), .RW(RW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dvd),
        .i_den   (r_d),
        .o_done  (w_dv_done),
        .o_quot  (w_quot)
    );

    // saturate and apply the sign of the numerator
    always_comb begin
        if (r_num[NW-1]) begin
            w_sat = (w_quot > NEG_LIM) ? SCORE_BITS'(32'h8000_0000)
                                       : SCORE_BITS'(-w_quot);
        end else begin
            w_sat = (w_quot > POS_LIM) ? SCORE_BITS'(32'h7FFF_FFFF)
                                       : w_quot[SCORE_BITS-1:0];
        end
    end

    assign w_fin = (r_k + 1'b1 == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_gain  <= GAIN_RESET;
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_acc) begin
                        r_last <= i_data.last;
                        r_nsh  <= w_full ? r_count : r_count + 1'b1;
                        r_qsh  <= VW'(r_sq);
                        r_nq   <= '0;
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SUMW'(i_data.sample);
                            r_x     <= i_data.sample;
                            r_state <= ST_ACC;
                        end else begin
                            r_ovf <= 1'b1;
                            if (i_data.last) begin
                                r_state <= ST_NQ;
                            end
                        end
                    end
                end
                ST_ACC: begin
                    r_sq  <= r_sq + SQW'(w_x2);
                    r_qsh <= VW'(r_sq + SQW'(w_x2));
                    r_state <= r_last ? ST_NQ : ST_LOAD;
                end
                ST_NQ: begin
                    // shift-add of n times Q, one bit of n a cycle; S*S settles meanwhile
                    if (r_nsh[0]) begin
                        r_nq <= r_nq + r_qsh;
                    end
                    r_ss  <= w_ss;
                    r_nsh <= r_nsh >> 1;
                    r_qsh <= r_qsh << 1;
                    if (r_nsh[CW-1:1] == '0) begin
                        r_state <= ST_SS;
                    end
                end
                ST_SS: begin
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (w_sq_done) begin
                        r_d     <= w_root;
                        r_k     <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_NUM;
                end
                ST_NUM: begin
                    r_num   <= w_nx - NW'(r_sum);
                    r_state <= ST_PROD;
                end
                ST_PROD: begin
                    if (r_d == '0) begin
                        r_score <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_dv_done) begin
                        r_score <= w_sat;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        if (w_fin) begin
                            r_count <= '0;
                            r_sum   <= '0;
                            r_sq    <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_RD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assign o_valid          = (r_state == ST_OUT);
    assign o_data.score     = r_score;
    assign o_data.dropped   = r_ovf;
    assign o_data.final_res = w_fin;
endmodule
`default_nettype wire

[rtl/zsn_checker.sv]
// port-level checks of the window z-score normalizer and their bind
`default_nettype none
module zsn_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire zsn_pkg::t_zsn_out o_data
);
    // a held beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // no input is taken while results are emitted
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during output");

    // an accepted sample is never followed at once by a result
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !o_valid)
        else $error("result right after input beat");

    // the last beat of a window ends the burst
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_data.final_res |=> !o_valid)
        else $error("beat after final result");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind window_zscore_normalizer zsn_checker u_zsn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire
